FILE: rtl/vt4_pkg.sv
package vt4_pkg;

    localparam int COEF_W             = 16;
    localparam int VEC_W              = 32;
    localparam int NUM_COLS           = 4;
    localparam int NUM_ROWS           = 4;
    localparam int ROW_W              = COEF_W * NUM_COLS;
    localparam int PROD_W             = COEF_W + VEC_W;
    localparam int PAIR_W             = PROD_W + 1;
    localparam int SUM_W              = PAIR_W + 1;
    localparam int COEF_FRAC_BITS_DEF = 12;
    localparam int CFG_IDX_W          = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0 = 2'd0,
        REG_ROW1 = 2'd1,
        REG_ROW2 = 2'd2,
        REG_ROW3 = 2'd3
    } cfg_idx_t;

    // One finished output component together with its clamp flag.
    typedef struct packed {
        logic signed [VEC_W-1:0] value;
        logic                    sat;
    } row_res_t;

endpackage

FILE: rtl/vt4_mul.sv
module vt4_mul
    import vt4_pkg::*;
(
    input  logic                     clk,
    input  logic [ROW_W-1:0]         row,
    input  logic signed [VEC_W-1:0]  vin  [NUM_COLS],
    output logic signed [PROD_W-1:0] prod [NUM_COLS]
);

    logic signed [PROD_W-1:0] prod_next [NUM_COLS];

    // Both operands are sign-extended to the product width before the multiply.
    always_comb
    begin
        for (int j = 0; j < NUM_COLS; j++)
        begin
            prod_next[j] = PROD_W'($signed(row[j*COEF_W +: COEF_W])) * PROD_W'(vin[j]);
        end
    end

    logic signed [PROD_W-1:0] prod_reg [NUM_COLS];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NUM_COLS; j++)
        begin
            prod_reg[j] <= prod_next[j];
        end
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/vt4_reduce.sv
module vt4_reduce
    import vt4_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic signed [PROD_W-1:0] prod [NUM_COLS],
    output row_res_t                 res
);

    localparam logic signed [SUM_W-1:0] MAX_OUT =
        {{(SUM_W-VEC_W+1){1'b0}}, {(VEC_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] MIN_OUT =
        {{(SUM_W-VEC_W+1){1'b1}}, {(VEC_W-1){1'b0}}};

    logic signed [PAIR_W-1:0] pair0_reg;
    logic signed [PAIR_W-1:0] pair1_reg;
    logic signed [PAIR_W-1:0] pair0_next;
    logic signed [PAIR_W-1:0] pair1_next;

    assign pair0_next = PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
    assign pair1_next = PAIR_W'(prod[2]) + PAIR_W'(prod[3]);

    always_ff @(posedge clk)
    begin
        pair0_reg <= pair0_next;
        pair1_reg <= pair1_next;
    end

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] shifted;
    row_res_t                res_next;
    row_res_t                res_reg;

    // Arithmetic shift floors toward minus infinity, then clamp to 32 bits.
    always_comb
    begin
        sum     = SUM_W'(pair0_reg) + SUM_W'(pair1_reg);
        shifted = sum >>> COEF_FRAC_BITS;
        if (shifted > MAX_OUT)
        begin
            res_next.value = MAX_OUT[VEC_W-1:0];
            res_next.sat   = 1'b1;
        end
        else if (shifted < MIN_OUT)
        begin
            res_next.value = MIN_OUT[VEC_W-1:0];
            res_next.sat   = 1'b1;
        end
        else
        begin
            res_next.value = shifted[VEC_W-1:0];
            res_next.sat   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

FILE: rtl/vertex_transform_4x4.sv
// Transforms one homogeneous Q16.16 vertex by a 4x4 matrix of signed coefficients with
// COEF_FRAC_BITS fraction bits, one vertex per clock. A request is taken on every cycle
// that start is high (busy never rises), and its result appears on
// out_x..out_w with done high for exactly one cycle; the receiver must take it then.
// The pipeline stages are the coefficient multipliers, a first adder level and a final adder
// level with the floor shift and 32-bit saturation. Load the four row registers through
// the cfg port only while no vertex is in flight.
module vertex_transform_4x4
    import vt4_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [VEC_W-1:0] in_x,
    input  logic signed [VEC_W-1:0] in_y,
    input  logic signed [VEC_W-1:0] in_z,
    input  logic signed [VEC_W-1:0] in_w,
    output logic                    done,
    output logic signed [VEC_W-1:0] out_x,
    output logic signed [VEC_W-1:0] out_y,
    output logic signed [VEC_W-1:0] out_z,
    output logic signed [VEC_W-1:0] out_w,
    output logic                    saturated,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [ROW_W-1:0]        cfg_data
);

    logic [ROW_W-1:0] row_reg [NUM_ROWS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                row_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_ROW0: row_reg[0] <= cfg_data;
                REG_ROW1: row_reg[1] <= cfg_data;
                REG_ROW2: row_reg[2] <= cfg_data;
                REG_ROW3: row_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline never stalls, so a request is accepted on every start.
    assign busy = 1'b0;

    logic signed [VEC_W-1:0] vin [NUM_COLS];

    assign vin[0] = in_x;
    assign vin[1] = in_y;
    assign vin[2] = in_z;
    assign vin[3] = in_w;

    row_res_t res [NUM_ROWS];

    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_row
        logic signed [PROD_W-1:0] prod [NUM_COLS];

        vt4_mul u_mul (
            .clk  (clk),
            .row  (row_reg[r]),
            .vin  (vin),
            .prod (prod)
        );

        vt4_reduce #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_reduce (
            .clk  (clk),
            .prod (prod),
            .res  (res[r])
        );
    end

    logic v1_reg;
    logic v2_reg;
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    assign done      = done_reg;
    assign out_x     = res[0].value;
    assign out_y     = res[1].value;
    assign out_z     = res[2].value;
    assign out_w     = res[3].value;
    assign saturated = res[0].sat | res[1].sat | res[2].sat | res[3].sat;

    localparam logic signed [VEC_W-1:0] OUT_MAX = {1'b0, {(VEC_W-1){1'b1}}};
    localparam logic signed [VEC_W-1:0] OUT_MIN = {1'b1, {(VEC_W-1){1'b0}}};

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("done without a request three cycles earlier");

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted request produced no result");

    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (out_x == OUT_MAX || out_x == OUT_MIN ||
                                 out_y == OUT_MAX || out_y == OUT_MIN ||
                                 out_z == OUT_MAX || out_z == OUT_MIN ||
                                 out_w == OUT_MAX || out_w == OUT_MIN))
        else $error("saturated flag without a clamped component");

endmodule

FILE: test/vertex_transform_4x4_tb.sv
`timescale 1ns / 100ps

module vertex_transform_4x4_tb;
    import vt4_pkg::*;

    localparam int FRAC            = COEF_FRAC_BITS_DEF;
    localparam int LATENCY         = 3;
    localparam int RANDOM_PHASES   = 10;
    localparam int VERTS_PER_PHASE = 105;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_LIMIT     = 1000;

    localparam longint OUT_MAX = 64'sd2147483647;
    localparam longint OUT_MIN = -64'sd2147483648;

    localparam logic [VEC_W-1:0]  V_MAX    = 32'h7FFF_FFFF;
    localparam logic [VEC_W-1:0]  V_MIN    = 32'h8000_0000;
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC);
    localparam logic [COEF_W-1:0] COEF_POS = 16'h7FFF;
    localparam logic [COEF_W-1:0] COEF_NEG = 16'h8000;

    localparam cfg_idx_t ROW_REG [NUM_ROWS] = '{REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3};

    typedef logic [NUM_COLS-1:0][VEC_W-1:0] vertex_t;
    typedef logic [NUM_ROWS-1:0][ROW_W-1:0] matrix_t;

    typedef struct packed {
        vertex_t comp;
        logic    sat;
    } transformed_t;

    typedef struct packed {
        logic         load;
        matrix_t      rows;
        vertex_t      vtx;
        logic         typed;
        transformed_t want;
    } directed_row_t;

    typedef enum {
        COEFS_FULL,
        COEFS_NEAR_UNIT,
        COEFS_EXTREME,
        COEFS_SPARSE
    } coef_mix_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    start     = 1'b0;
    logic                    busy;
    logic signed [VEC_W-1:0] in_x      = '0;
    logic signed [VEC_W-1:0] in_y      = '0;
    logic signed [VEC_W-1:0] in_z      = '0;
    logic signed [VEC_W-1:0] in_w      = '0;
    logic                    done;
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic signed [VEC_W-1:0] out_w;
    logic                    saturated;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    cfg_idx_t                cfg_index = REG_ROW0;
    logic [ROW_W-1:0]        cfg_data  = '0;

    // Shadow copy of the coefficient rows, updated when a write is accepted.
    matrix_t         coef_rows = '0;
    transformed_t    pending_q[$];
    directed_row_t   directed[$];
    int              mismatches = 0;
    int              cycles     = 0;

    vertex_transform_4x4 #(
        .COEF_FRAC_BITS(FRAC)
    ) DUT (
        .*
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Each component is the exact dot product, floored by the fraction shift and clamped.
    function automatic transformed_t transform_vertex(input matrix_t m, input vertex_t v);
        transformed_t            r;
        longint                  acc;
        logic signed [COEF_W-1:0] c;
        logic signed [VEC_W-1:0]  p;
        r.sat = 1'b0;
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            acc = 0;
            for (int j = 0; j < NUM_COLS; j++)
            begin
                c = m[i][j*COEF_W +: COEF_W];
                p = v[j];
                acc += longint'(c) * longint'(p);
            end
            acc = acc >>> FRAC;
            if (acc > OUT_MAX)
            begin
                acc   = OUT_MAX;
                r.sat = 1'b1;
            end
            else if (acc < OUT_MIN)
            begin
                acc   = OUT_MIN;
                r.sat = 1'b1;
            end
            r.comp[i] = acc[VEC_W-1:0];
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        transformed_t want;
        vertex_t      got;
        if (rst_n && done)
        begin
            got = {out_w, out_z, out_y, out_x};
            if (pending_q.size() == 0)
                report_mismatch("result with no vertex outstanding");
            else
            begin
                want = pending_q.pop_front();
                for (int i = 0; i < NUM_COLS; i++)
                    if (got[i] !== want.comp[i])
                        report_mismatch($sformatf("component %0d got %h expected %h",
                                                  i, got[i], want.comp[i]));
                if (saturated !== want.sat)
                    report_mismatch($sformatf("saturated got %b expected %b",
                                              saturated, want.sat));
            end
        end
    end

    function automatic vertex_t vec(input logic [VEC_W-1:0] x, input logic [VEC_W-1:0] y,
                                    input logic [VEC_W-1:0] z, input logic [VEC_W-1:0] w);
        return {w, z, y, x};
    endfunction

    function automatic transformed_t outs(input logic [VEC_W-1:0] x, input logic [VEC_W-1:0] y,
                                          input logic [VEC_W-1:0] z, input logic [VEC_W-1:0] w,
                                          input logic sat);
        return {w, z, y, x, sat};
    endfunction

    function automatic matrix_t rows(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                                     input logic [ROW_W-1:0] r2, input logic [ROW_W-1:0] r3);
        return {r3, r2, r1, r0};
    endfunction

    function automatic matrix_t uniform_rows(input logic [COEF_W-1:0] c);
        return rows({4{c}}, {4{c}}, {4{c}}, {4{c}});
    endfunction

    task automatic add_load(input matrix_t m);
        directed.push_back('{load: 1'b1, rows: m, vtx: '0, typed: 1'b0, want: '0});
    endtask

    task automatic add_vtx(input vertex_t v, input logic typed, input transformed_t want);
        directed.push_back('{load: 1'b0, rows: '0, vtx: v, typed: typed, want: want});
    endtask

    task automatic build_directed();
        // Registers hold zero after reset, so every output is zero.
        add_vtx(vec(V_MAX, V_MAX, V_MAX, V_MAX), 1'b1, outs(0, 0, 0, 0, 1'b0));
        add_vtx(vec(V_MIN, V_MIN, V_MIN, V_MIN), 1'b1, outs(0, 0, 0, 0, 1'b0));

        // Identity passes the vertex through unchanged.
        add_load(rows({48'd0, COEF_ONE}, {32'd0, COEF_ONE, 16'd0},
                      {16'd0, COEF_ONE, 32'd0}, {COEF_ONE, 48'd0}));
        add_vtx(vec(V_MAX, V_MIN, 32'd1, 32'hFFFF_FFFF), 1'b1,
                outs(V_MAX, V_MIN, 32'd1, 32'hFFFF_FFFF, 1'b0));
        add_vtx(vec(32'h1234_5678, 32'hEDCB_A988, 32'h0001_0000, 32'hFFFF_0000), 1'b1,
                outs(32'h1234_5678, 32'hEDCB_A988, 32'h0001_0000, 32'hFFFF_0000, 1'b0));

        // Largest coefficients against the largest vertices clamp in both directions.
        add_load(uniform_rows(COEF_POS));
        add_vtx(vec(V_MAX, V_MAX, V_MAX, V_MAX), 1'b1, outs(V_MAX, V_MAX, V_MAX, V_MAX, 1'b1));
        add_vtx(vec(V_MIN, V_MIN, V_MIN, V_MIN), 1'b1, outs(V_MIN, V_MIN, V_MIN, V_MIN, 1'b1));
        add_load(uniform_rows(COEF_NEG));
        add_vtx(vec(V_MIN, V_MIN, V_MIN, V_MIN), 1'b1, outs(V_MAX, V_MAX, V_MAX, V_MAX, 1'b1));
        add_vtx(vec(V_MAX, V_MAX, V_MAX, V_MAX), 1'b1, outs(V_MIN, V_MIN, V_MIN, V_MIN, 1'b1));

        // The smallest coefficient on x shows that the shift floors instead of rounding.
        add_load(rows(64'd1, 64'd1, 64'd1, 64'd1));
        add_vtx(vec(32'hFFFF_FFFF, V_MAX, V_MIN, V_MAX), 1'b1,
                outs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        add_vtx(vec(32'd4095, V_MIN, V_MAX, V_MIN), 1'b1, outs(0, 0, 0, 0, 1'b0));
        add_vtx(vec(32'd4096, 0, 0, 0), 1'b1, outs(1, 1, 1, 1, 1'b0));
        add_vtx(vec(-32'sd4096, 0, 0, 0), 1'b1,
                outs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        add_vtx(vec(-32'sd4097, 0, 0, 0), 1'b1,
                outs(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b0));

        // Sums and differences that sit just at or just past the 32-bit range.
        add_load(rows({32'd0, COEF_ONE, COEF_ONE}, {32'd0, 16'hF000, COEF_ONE},
                      {COEF_ONE, COEF_ONE, 32'd0}, 64'h7FFF_8000_0001_FFFF));
        add_vtx(vec(V_MAX, 32'd0, V_MAX, 32'd1), 1'b0, '0);
        add_vtx(vec(V_MAX, 32'd1, V_MIN, 32'hFFFF_FFFF), 1'b0, '0);
        add_vtx(vec(V_MIN, 32'hFFFF_FFFF, V_MIN, 32'd0), 1'b0, '0);
    endtask

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef(input coef_mix_t mix);
        logic [COEF_W-1:0] c;
        c = COEF_W'($urandom_range(0, 12288)) - 16'd6144;
        case (mix)
            COEFS_FULL:
                c = COEF_W'($urandom);
            COEFS_NEAR_UNIT:
                ;
            COEFS_EXTREME:
                case ($urandom_range(0, 4))
                    0:       c = COEF_POS;
                    1:       c = COEF_NEG;
                    2:       c = '0;
                    3:       c = COEF_ONE;
                    default: c = -COEF_ONE;
                endcase
            default:
                if ($urandom_range(0, 2) != 0)
                    c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [VEC_W-1:0] rand_component();
        logic [VEC_W-1:0] s;
        int unsigned      roll;
        s    = $urandom;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return s;
        if (roll < 7)
            return {{11{s[20]}}, s[20:0]};
        if (roll < 9)
            return {{7{s[24]}}, s[24:0]};
        case ($urandom_range(0, 4))
            0:       return V_MAX;
            1:       return V_MIN;
            2:       return '0;
            3:       return 32'd1;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic send_vertex(input vertex_t v, input int gap, input logic typed,
                               input transformed_t want);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        in_x  <= v[0];
        in_y  <= v[1];
        in_z  <= v[2];
        in_w  <= v[3];
        do @(posedge clk); while (busy);
        pending_q.push_back(typed ? want : transform_vertex(coef_rows, v));
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // Coefficients change only once every outstanding vertex has come back or the drain limit runs out.
    task automatic load_matrix(input matrix_t m, input logic [NUM_ROWS-1:0] mask);
        int gap;
        drain_results();
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (mask[r])
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
                if (gap > 0)
                begin
                    cfg_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                cfg_valid <= 1'b1;
                cfg_index <= ROW_REG[r];
                cfg_data  <= m[r];
                do @(posedge clk); while (!cfg_ready);
                coef_rows[r] = m[r];
            end
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        matrix_t       m;
        vertex_t       v;
        coef_mix_t     mix;
        logic          no_idle;
        directed_row_t step;

        build_directed();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            step = directed[i];
            if (step.load)
                load_matrix(step.rows, '1);
            else
                send_vertex(step.vtx, pick_gap(), step.typed, step.want);
        end

        // Later phases reload a random subset of the rows, so old rows can mix with new ones.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            mix = coef_mix_t'(p % 4);
            for (int r = 0; r < NUM_ROWS; r++)
                for (int c = 0; c < NUM_COLS; c++)
                    m[r][c*COEF_W +: COEF_W] = rand_coef(mix);
            load_matrix(m, (p == 0) ? '1 : NUM_ROWS'($urandom));
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < VERTS_PER_PHASE; k++)
            begin
                for (int c = 0; c < NUM_COLS; c++)
                    v[c] = rand_component();
                send_vertex(v, no_idle ? 0 : pick_gap(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (LATENCY + 2) @(posedge clk);
        if (pending_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_q.size()));
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
